// File: rtl/core/fdm_pkg.sv
`default_nettype none
package fdm_pkg;

  localparam int unsigned MAX_PIXELS = 65536;
  localparam int unsigned POS_W      = $clog2(MAX_PIXELS);
  localparam int unsigned LEN_W      = POS_W + 1;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned CFG_W      = 9;
  localparam int unsigned IDX_W      = 2;
  localparam int unsigned AREA_W     = 2 * DIM_W;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned PROD_W     = PIX_W + COEF_W;

  // luma weights, unsigned Q16, sum is exactly 1.0
  localparam logic [COEF_W-1:0] W_RED   = 16'd20224;
  localparam logic [COEF_W-1:0] W_GREEN = 16'd39938;
  localparam logic [COEF_W-1:0] W_BLUE  = 16'd5374;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 9'd64;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 9'd64;
  localparam logic [PIX_W-1:0] THR_RST    = 8'd127;

  localparam logic [PIX_W-1:0] ALPHA_ON  = 8'hFF;
  localparam logic [PIX_W-1:0] ALPHA_OFF = 8'h00;

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_THRESHOLD    = 2'd2
  } fdm_reg_t;

  // store slot for the next accepted word
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             primed;
  } fdm_slot_t;

endpackage
`default_nettype wire

// File: rtl/core/fdm_if.sv
`default_nettype none
interface fdm_in_if;
  logic                        valid;
  logic                        ready;
  logic [fdm_pkg::PIX_W-1:0]   red;
  logic [fdm_pkg::PIX_W-1:0]   green;
  logic [fdm_pkg::PIX_W-1:0]   blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface fdm_out_if;
  logic                        valid;
  logic                        ready;
  logic [fdm_pkg::PIX_W-1:0]   red_out;
  logic [fdm_pkg::PIX_W-1:0]   green_out;
  logic [fdm_pkg::PIX_W-1:0]   blue_out;
  logic [fdm_pkg::PIX_W-1:0]   motion_alpha;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output motion_alpha, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input motion_alpha, output ready);
endinterface
`default_nettype wire

// File: rtl/core/frame_difference_motion_mask_core.sv
// An accepted input word passes the stage 1, 2 and 3 registers to its result word on out_ch.
// Throughput: one word per cycle while out_ch is ready, set by the three-stage pipeline (multiply,
// sum, compare) and the grey store's one write and one read port per cycle.
// Reset (rst_n low, synchronous): pipeline emptied, registers to defaults,
// position zero, stored grey treated as zero until a full frame is written.
`default_nettype none
module frame_difference_motion_mask_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  fdm_in_if.sink                           in_ch,
  fdm_out_if.source                        out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [fdm_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [fdm_pkg::CFG_W-1:0]   cfg_data
);

  fdm_pkg::fdm_slot_t        slot;
  logic [fdm_pkg::PIX_W-1:0] threshold;
  logic                      accept;

  assign accept = in_ch.valid && in_ch.ready;

  fdm_frame_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .slot      (slot),
    .threshold (threshold)
  );

  fdm_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .slot      (slot),
    .threshold (threshold)
  );

endmodule
`default_nettype wire

// File: rtl/core/fdm_frame_ctrl.sv
`default_nettype none
module fdm_frame_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [fdm_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [fdm_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                        accept,
  output      fdm_pkg::fdm_slot_t          slot,
  output      logic [fdm_pkg::PIX_W-1:0]   threshold
);

  logic [fdm_pkg::DIM_W-1:0]  width_r, width_nxt;
  logic [fdm_pkg::DIM_W-1:0]  height_r, height_nxt;
  logic [fdm_pkg::PIX_W-1:0]  thr_r, thr_nxt;
  logic [fdm_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic                       primed_r, primed_nxt;
  logic [fdm_pkg::AREA_W-1:0] area;
  logic [fdm_pkg::LEN_W-1:0]  len;
  logic [fdm_pkg::LEN_W-1:0]  pos_inc;
  logic                       size_wr;

  assign area = fdm_pkg::AREA_W'(width_r) * fdm_pkg::AREA_W'(height_r);

  always_comb begin
    if (area == '0) begin
      len = fdm_pkg::LEN_W'(1);
    end else if (area > fdm_pkg::AREA_W'(fdm_pkg::MAX_PIXELS)) begin
      len = fdm_pkg::LEN_W'(fdm_pkg::MAX_PIXELS);
    end else begin
      len = fdm_pkg::LEN_W'(area);
    end
  end

  assign pos_inc = fdm_pkg::LEN_W'(pos_r) + fdm_pkg::LEN_W'(1);
  assign size_wr = cfg_we && ((cfg_index == fdm_pkg::REG_FRAME_WIDTH) ||
                              (cfg_index == fdm_pkg::REG_FRAME_HEIGHT));

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    thr_nxt    = thr_r;
    pos_nxt    = pos_r;
    primed_nxt = primed_r;
    if (cfg_we) begin
      case (cfg_index)
        fdm_pkg::REG_FRAME_WIDTH:  width_nxt  = cfg_data;
        fdm_pkg::REG_FRAME_HEIGHT: height_nxt = cfg_data;
        fdm_pkg::REG_THRESHOLD:    thr_nxt    = cfg_data[fdm_pkg::PIX_W-1:0];
        default:                   thr_nxt    = thr_r;
      endcase
    end
    if (size_wr) begin
      pos_nxt    = '0;
      primed_nxt = 1'b0;
    end else if (accept) begin
      if (pos_inc >= len) begin
        pos_nxt    = '0;
        primed_nxt = 1'b1;
      end else begin
        pos_nxt = pos_inc[fdm_pkg::POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= fdm_pkg::WIDTH_RST;
      height_r <= fdm_pkg::HEIGHT_RST;
      thr_r    <= fdm_pkg::THR_RST;
      pos_r    <= '0;
      primed_r <= 1'b0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      thr_r    <= thr_nxt;
      pos_r    <= pos_nxt;
      primed_r <= primed_nxt;
    end
  end

  assign slot.pos    = pos_r;
  assign slot.primed = primed_r;
  assign threshold   = thr_r;

endmodule
`default_nettype wire

// File: rtl/core/fdm_pipe.sv
`default_nettype none
module fdm_pipe (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  fdm_in_if.sink                         in_ch,
  fdm_out_if.source                      out_ch,
  input  wire fdm_pkg::fdm_slot_t        slot,
  input  wire logic [fdm_pkg::PIX_W-1:0] threshold
);

  localparam int unsigned PW = fdm_pkg::PIX_W;
  localparam int unsigned QW = fdm_pkg::PROD_W;
  localparam int unsigned AW = fdm_pkg::POS_W;

  // grey store; entries are only trusted once the frame has wrapped
  logic [PW-1:0] mem [fdm_pkg::MAX_PIXELS];

  // stage 1: products and store read
  logic          s1_valid_r;
  logic [PW-1:0] s1_red_r, s1_green_r, s1_blue_r;
  logic [QW-1:0] s1_pr_r, s1_pg_r, s1_pb_r;
  logic [AW-1:0] s1_pos_r;
  logic          s1_primed_r;
  logic [PW-1:0] s1_rd_r;
  logic          s1_fwd_r, s1_fwd_nxt;
  logic [PW-1:0] s1_fwdval_r, s1_fwdval_nxt;
  logic [PW-1:0] s1_prev;

  // stage 2: grey
  logic          s2_valid_r;
  logic [PW-1:0] s2_red_r, s2_green_r, s2_blue_r;
  logic [PW-1:0] s2_grey_r;
  logic [PW-1:0] s2_prev_r, s2_prev_nxt;
  logic [AW-1:0] s2_pos_r;
  logic [QW-1:0] s1_sum;

  // stage 3: output word
  logic          s3_valid_r;
  logic [PW-1:0] s3_red_r, s3_green_r, s3_blue_r, s3_alpha_r, s3_alpha_nxt;
  logic [PW:0]   diff;

  logic s3_en, s2_en, s1_en, wr_en;

  assign s3_en  = !s3_valid_r || out_ch.ready;
  assign s2_en  = !s2_valid_r || s3_en;
  assign s1_en  = !s1_valid_r || s2_en;
  assign wr_en  = s2_valid_r && s3_en;

  assign in_ch.ready = s1_en;

  // store write forwarding into stage 1
  always_comb begin
    s1_fwd_nxt    = s1_fwd_r;
    s1_fwdval_nxt = s1_fwdval_r;
    if (s1_en) begin
      s1_fwd_nxt    = wr_en && (s2_pos_r == slot.pos);
      s1_fwdval_nxt = s2_grey_r;
    end else if (wr_en && (s2_pos_r == s1_pos_r)) begin
      s1_fwd_nxt    = 1'b1;
      s1_fwdval_nxt = s2_grey_r;
    end
  end

  always_comb begin
    if (s1_fwd_r) begin
      s1_prev = s1_fwdval_r;
    end else if (s1_primed_r) begin
      s1_prev = s1_rd_r;
    end else begin
      s1_prev = '0;
    end
    if (wr_en && (s2_pos_r == s1_pos_r)) begin
      s2_prev_nxt = s2_grey_r;
    end else begin
      s2_prev_nxt = s1_prev;
    end
  end

  assign s1_sum = s1_pr_r + s1_pg_r + s1_pb_r;

  always_comb begin
    if (s2_grey_r >= s2_prev_r) begin
      diff = {1'b0, s2_grey_r} - {1'b0, s2_prev_r};
    end else begin
      diff = {1'b0, s2_prev_r} - {1'b0, s2_grey_r};
    end
    s3_alpha_nxt = (diff > {1'b0, threshold}) ? fdm_pkg::ALPHA_ON : fdm_pkg::ALPHA_OFF;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s2_pos_r] <= s2_grey_r;
    end
    if (s1_en) begin
      s1_rd_r <= mem[slot.pos];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s1_fwd_r   <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s2_en) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_en) begin
        s3_valid_r <= s2_valid_r;
      end
      s1_fwd_r <= s1_fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_fwdval_r <= s1_fwdval_nxt;
    if (s1_en) begin
      s1_red_r    <= in_ch.red;
      s1_green_r  <= in_ch.green;
      s1_blue_r   <= in_ch.blue;
      s1_pr_r     <= QW'(in_ch.red) * QW'(fdm_pkg::W_RED);
      s1_pg_r     <= QW'(in_ch.green) * QW'(fdm_pkg::W_GREEN);
      s1_pb_r     <= QW'(in_ch.blue) * QW'(fdm_pkg::W_BLUE);
      s1_pos_r    <= slot.pos;
      s1_primed_r <= slot.primed;
    end
    if (s2_en) begin
      s2_red_r   <= s1_red_r;
      s2_green_r <= s1_green_r;
      s2_blue_r  <= s1_blue_r;
      s2_grey_r  <= s1_sum[QW-1:QW-PW];
      s2_prev_r  <= s2_prev_nxt;
      s2_pos_r   <= s1_pos_r;
    end
    if (s3_en) begin
      s3_red_r   <= s2_red_r;
      s3_green_r <= s2_green_r;
      s3_blue_r  <= s2_blue_r;
      s3_alpha_r <= s3_alpha_nxt;
    end
  end

  assign out_ch.valid        = s3_valid_r;
  assign out_ch.red_out      = s3_red_r;
  assign out_ch.green_out    = s3_green_r;
  assign out_ch.blue_out     = s3_blue_r;
  assign out_ch.motion_alpha = s3_alpha_r;

endmodule
`default_nettype wire

// File: rtl/core/fdm_checker.sv
`default_nettype none
module fdm_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [fdm_pkg::PIX_W-1:0] out_red,
  input wire logic [fdm_pkg::PIX_W-1:0] out_alpha
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_red) && $stable(out_alpha))
    else $error("result word changed while stalled");

  a_alpha_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_alpha == fdm_pkg::ALPHA_ON) || (out_alpha == fdm_pkg::ALPHA_OFF))
    else $error("alpha is neither on nor off");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind frame_difference_motion_mask_core fdm_checker u_fdm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_red   (out_ch.red_out),
  .out_alpha (out_ch.motion_alpha)
);
`default_nettype wire
